>>> hw/rtl/complex_fir_filter_assert.svh
// Assertion macros used by the checker file
`ifndef COMPLEX_FIR_FILTER_ASSERT_SVH
`define COMPLEX_FIR_FILTER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent
`define CFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define CFF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/comf_pkg.sv
`default_nettype none

package comf_pkg;

  // Filter geometry
  localparam int TAPS  = 64;
  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int DW    = 16;
  localparam int IDX_W = 6;
  // Q2.30 products, complex combine and TAPS-fold growth
  localparam int ACC_W = 2 * DW + 2 + CNT_W;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_CPLX = 2'd1,
    OP_REAL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_FIN
  } st_e;

  // Controls broadcast to every cell of the ring
  typedef struct packed {
    logic shift;  // new sample enters cell 0, rest move one place down the line
    logic rot;    // whole ring rotates one place towards cell 0
  } cell_ctl_t;

  // Controls of the multiply-accumulate unit
  typedef struct packed {
    logic clr;      // clear the accumulators
    logic prod_en;  // capture products of the pair in cell 0
    logic cplx;     // complex transaction, otherwise real only
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/comf_cell.sv
`default_nettype none

module comf_cell import comf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctl_t            ctl_i,
  input  logic                 coef_we_i,
  input  logic signed [DW-1:0] ld_re_i,
  input  logic signed [DW-1:0] ld_im_i,
  input  logic signed [DW-1:0] left_re_i,
  input  logic signed [DW-1:0] left_im_i,
  input  logic signed [DW-1:0] right_re_i,
  input  logic signed [DW-1:0] right_im_i,
  input  logic signed [DW-1:0] right_cre_i,
  input  logic signed [DW-1:0] right_cim_i,
  output logic signed [DW-1:0] smp_re_o,
  output logic signed [DW-1:0] smp_im_o,
  output logic signed [DW-1:0] coef_re_o,
  output logic signed [DW-1:0] coef_im_o
);

  logic signed [DW-1:0] smp_re_q, smp_re_d, smp_im_q, smp_im_d;
  logic signed [DW-1:0] coef_re_q, coef_re_d, coef_im_q, coef_im_d;

  // Sample: rotate during a pass, shift on a new sample, else hold
  always_comb begin
    smp_re_d = smp_re_q;
    smp_im_d = smp_im_q;
    if (ctl_i.rot) begin
      smp_re_d = right_re_i;
      smp_im_d = right_im_i;
    end else if (ctl_i.shift) begin
      smp_re_d = left_re_i;
      smp_im_d = left_im_i;
    end
  end

  // Coefficient: rotates alongside the sample, loaded when addressed
  always_comb begin
    coef_re_d = coef_re_q;
    coef_im_d = coef_im_q;
    if (ctl_i.rot) begin
      coef_re_d = right_cre_i;
      coef_im_d = right_cim_i;
    end else if (coef_we_i) begin
      coef_re_d = ld_re_i;
      coef_im_d = ld_im_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_re_q  <= '0;
      smp_im_q  <= '0;
      coef_re_q <= '0;
      coef_im_q <= '0;
    end else begin
      smp_re_q  <= smp_re_d;
      smp_im_q  <= smp_im_d;
      coef_re_q <= coef_re_d;
      coef_im_q <= coef_im_d;
    end
  end

  assign smp_re_o  = smp_re_q;
  assign smp_im_o  = smp_im_q;
  assign coef_re_o = coef_re_q;
  assign coef_im_o = coef_im_q;

endmodule

`default_nettype wire

>>> hw/rtl/comf_mac.sv
`default_nettype none

module comf_mac import comf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_ctl_t             ctl_i,
  input  logic signed [DW-1:0] sr_i,
  input  logic signed [DW-1:0] si_i,
  input  logic signed [DW-1:0] cr_i,
  input  logic signed [DW-1:0] ci_i,
  output logic signed [DW-1:0] res_re_o,
  output logic signed [DW-1:0] res_im_o
);

  localparam int Q_W = ACC_W + 1 - (DW - 1);
  localparam logic signed [Q_W-1:0] QMax = Q_W'((1 << (DW - 1)) - 1);
  localparam logic signed [Q_W-1:0] QMin = Q_W'(-(1 << (DW - 1)));

  logic signed [2*DW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic                   prod_vld_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;

  // Round half up from Q10.30 to Q1.15, then saturate
  function automatic logic signed [DW-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] s;
    logic signed [Q_W-1:0] q;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(1 << (DW - 2));
    q = Q_W'(s >>> (DW - 1));
    if (q > QMax) begin
      round_sat = QMax[DW-1:0];
    end else if (q < QMin) begin
      round_sat = QMin[DW-1:0];
    end else begin
      round_sat = q[DW-1:0];
    end
  endfunction

  // Product stage; imaginary terms are dropped for a real transaction
  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      p_rr_q <= sr_i * cr_i;
      if (ctl_i.cplx) begin
        p_ii_q <= si_i * ci_i;
        p_ri_q <= sr_i * ci_i;
        p_ir_q <= si_i * cr_i;
      end else begin
        p_ii_q <= '0;
        p_ri_q <= '0;
        p_ir_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.prod_en;
    end
  end

  // Accumulate stage
  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (ctl_i.clr) begin
      acc_re_d = '0;
      acc_im_d = '0;
    end else if (prod_vld_q) begin
      acc_re_d = acc_re_q + ACC_W'(p_rr_q) - ACC_W'(p_ii_q);
      acc_im_d = acc_im_q + ACC_W'(p_ri_q) + ACC_W'(p_ir_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  assign res_re_o = round_sat(acc_re_q);
  assign res_im_o = round_sat(acc_im_q);

endmodule

`default_nettype wire

>>> hw/rtl/complex_fir_filter.sv
// Complex FIR filter, TAPS taps, Q1.15 samples and coefficients. Each tap is
// a cell holding one delay-line sample and one coefficient; cell k holds
// sample n-k and coefficient k. A coefficient load (opcode 0) gives no
// result; an index at or above TAPS and opcode 3 are dropped. A complex
// (opcode 1) or real (opcode 2) sample is shifted into cell 0, then the ring
// of cells rotates once through a single complex multiply-accumulate unit at
// cell 0, so a sample transaction occupies the input until it has shifted the
// sample in, made TAPS rotation steps, added the last product and rounded the
// sum into the output register. The result sits in that register, so the
// next transaction may be accepted while it waits to be taken; a pass that
// ends while the previous result is still waiting holds in its last cycle
// until that result is taken. Real samples are stored with a zero imaginary
// part and give out_im of zero. Delay line and coefficients reset to zero.
`default_nettype none

module complex_fir_filter import comf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              opcode_i,
  input  logic [IDX_W-1:0]        coef_index_i,
  input  logic signed [DW-1:0]    data_re_i,
  input  logic signed [DW-1:0]    data_im_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DW-1:0]    out_re_o,
  output logic signed [DW-1:0]    out_im_o
);

  st_e              state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cplx_q;
  logic             in_acc, smp_acc, ld_acc;
  logic             rot, out_ld;
  cell_ctl_t        cell_ctl;
  mac_ctl_t         mac_ctl;

  logic signed [DW-1:0] smp_re [TAPS];
  logic signed [DW-1:0] smp_im [TAPS];
  logic signed [DW-1:0] cf_re  [TAPS];
  logic signed [DW-1:0] cf_im  [TAPS];
  logic signed [DW-1:0] new_im;
  logic signed [DW-1:0] res_re, res_im;
  logic signed [DW-1:0] out_re_q, out_im_q;
  logic                 out_vld_q, out_vld_d;

  // Transaction decode
  assign in_acc  = in_valid_i && !in_stall_o;
  assign smp_acc = in_acc && (opcode_i == OP_CPLX || opcode_i == OP_REAL);
  assign ld_acc  = in_acc && (opcode_i == OP_LOAD);
  assign new_im  = (opcode_i == OP_CPLX) ? data_im_i : '0;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (smp_acc) state_d = ST_RUN;
      ST_RUN:  if (cnt_q == CNT_W'(TAPS - 1)) state_d = ST_WAIT;
      ST_WAIT: state_d = ST_FIN;
      ST_FIN:  if (out_ld) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    rot        = 1'b0;
    out_ld     = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_RUN:  rot = 1'b1;
      ST_WAIT: ;
      ST_FIN:  out_ld = !out_vld_q || !out_stall_i;
      default: ;
    endcase
  end

  assign cnt_d = rot ? cnt_q + 1'b1 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      cplx_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (smp_acc) begin
        cplx_q <= (opcode_i == OP_CPLX);
      end
    end
  end

  // Ring of tap cells
  assign cell_ctl.shift = smp_acc;
  assign cell_ctl.rot   = rot;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    localparam int Nxt = (k + 1) % TAPS;
    logic signed [DW-1:0] left_re, left_im;
    logic                 coef_we;

    if (k == 0) begin : g_head
      assign left_re = data_re_i;
      assign left_im = new_im;
    end else begin : g_body
      assign left_re = smp_re[k-1];
      assign left_im = smp_im[k-1];
    end

    assign coef_we = ld_acc && (int'(coef_index_i) == k);

    comf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .coef_we_i   (coef_we),
      .ld_re_i     (data_re_i),
      .ld_im_i     (data_im_i),
      .left_re_i   (left_re),
      .left_im_i   (left_im),
      .right_re_i  (smp_re[Nxt]),
      .right_im_i  (smp_im[Nxt]),
      .right_cre_i (cf_re[Nxt]),
      .right_cim_i (cf_im[Nxt]),
      .smp_re_o    (smp_re[k]),
      .smp_im_o    (smp_im[k]),
      .coef_re_o   (cf_re[k]),
      .coef_im_o   (cf_im[k])
    );
  end

  // Multiply-accumulate at cell 0
  assign mac_ctl.clr     = smp_acc;
  assign mac_ctl.prod_en = rot;
  assign mac_ctl.cplx    = cplx_q;

  comf_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .sr_i     (smp_re[0]),
    .si_i     (smp_im[0]),
    .cr_i     (cf_re[0]),
    .ci_i     (cf_im[0]),
    .res_re_o (res_re),
    .res_im_o (res_im)
  );

  // Output register
  assign out_vld_d = out_ld || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_re_q <= res_re;
      out_im_q <= res_im;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;

endmodule

`default_nettype wire

>>> hw/rtl/complex_fir_filter_chk.sv
`default_nettype none
`include "complex_fir_filter_assert.svh"

module complex_fir_filter_chk import comf_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic [1:0]           opcode_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic signed [DW-1:0] out_re_o,
  input wire logic signed [DW-1:0] out_im_o
);

  // A stalled result stays offered and unchanged
  `CFF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_re_o) && $stable(out_im_o), "stalled result changed")

  // A sample transaction occupies the input in the following cycle
  `CFF_ASSERT_NEXT(a_smp_busy, clk_i, rst_ni,
    in_valid_i && !in_stall_o && (opcode_i == OP_CPLX || opcode_i == OP_REAL),
    in_stall_o, "input free straight after a sample")

  // Loads and unused opcodes never block the input
  `CFF_ASSERT_NEXT(a_load_free, clk_i, rst_ni,
    in_valid_i && !in_stall_o && opcode_i != OP_CPLX && opcode_i != OP_REAL,
    !in_stall_o, "input blocked after a load")

  // A new result only appears at the end of a filter pass
  `CFF_ASSERT_NOW(a_out_src, clk_i, rst_ni, $rose(out_valid_o),
    $past(in_stall_o), "result without a filter pass")

endmodule

bind complex_fir_filter complex_fir_filter_chk u_chk (.*);

`default_nettype wire
